### sv/edit_distance_engine_unit_assert.svh
// assertion macros for the edit distance engine
`ifndef EDIT_DISTANCE_ENGINE_UNIT_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_UNIT_ASSERT_SVH

// antecedent holds, consequent must hold in the same cycle
`define EDE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edit distance engine check failed");

// antecedent holds, consequent must hold in the next cycle
`define EDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edit distance engine check failed");

`endif

### sv/ede_pkg.sv
// types and constants used by the edit distance engine top level
package ede_pkg;

   localparam int MAX_LEN_DEFAULT = 32;
   localparam int DIST_W          = 6;
   localparam int DIST_MAX        = 63;

   localparam logic [1:0] ACT_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] ACT_APPEND_SECOND = 2'd1;
   localparam logic [1:0] ACT_COMPUTE       = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              too_long;
   } rsp_type;

endpackage

### sv/ede_ram.sv
// generic single write, single read ram with registered read data
module ede_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/edit_distance_engine_unit.sv
// top level of the levenshtein edit distance engine
//
//   channel   ports                         direction  beat accepted when
//   request   start, busy, req_data         in         start && !busy
//   response  rsp_valid, rsp_data           out        rsp_valid (one cycle)
//
// append beats (action 0 or 1) store the symbol without raising busy, or set the overflow flag when full
// a compute beat holds busy while it walks all cells of the m by n table, m and n being the kept
// lengths: a row setup state for each row, then a ram read state and a shared min unit state for each cell
// an empty first string answers right away with the second length
// reset is synchronous active high, clears lengths, overflow flag, response valid and sequencer
// the receiver cannot stall: the response shows for exactly one cycle
module edit_distance_engine_unit #(
   parameter int MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ede_pkg::req_type req_data,
   output logic             rsp_valid,
   output ede_pkg::rsp_type rsp_data
);

   // cost, length and counter width: values run 0 .. MAX_LEN
   localparam int CW  = $clog2(MAX_LEN + 1);
   // string ram address width
   localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_ROW       = 4'b0010,
      ST_CELL_RD   = 4'b0100,
      ST_CELL_CALC = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    i_ff, i_in;          // current row, 1 .. m
   logic [CW-1:0]    j_ff, j_in;          // current column, 1 .. n
   logic [CW-1:0]    left_ff, left_in;    // cost just computed in this row
   logic [CW-1:0]    diag_ff, diag_in;    // previous row, previous column
   logic [CW-1:0]    len_a_ff, len_a_in;
   logic [CW-1:0]    len_b_ff, len_b_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ede_pkg::rsp_type rsp_ff, rsp_in;

   // ram hookup
   logic             a_we, b_we, row_we;
   logic [SAW-1:0]   a_rd_addr, b_rd_addr;
   logic [7:0]       a_q, b_q;
   logic [CW-1:0]    row_q;
   logic [CW-1:0]    i_minus1, j_minus1;

   // shared cell unit
   logic [CW-1:0]    up_cost;
   logic [CW-1:0]    min_cost;
   logic [CW-1:0]    cell_cost;

   // finish path
   logic             finish;
   logic [CW-1:0]    fin_cost;
   logic [15:0]      fin_wide;
   logic             accept;

   assign accept   = start && !busy;
   assign i_minus1 = i_ff - CW'(1);
   assign j_minus1 = j_ff - CW'(1);

   assign a_rd_addr = i_minus1[SAW-1:0];
   assign b_rd_addr = j_minus1[SAW-1:0];

   ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (len_a_ff[SAW-1:0]),
      .wr_data (req_data.symbol),
      .rd_addr (a_rd_addr),
      .rd_data (a_q)
   );

   ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (len_b_ff[SAW-1:0]),
      .wr_data (req_data.symbol),
      .rd_addr (b_rd_addr),
      .rd_data (b_q)
   );

   // one row of costs, column index used directly as address
   ede_ram #(.WIDTH(CW), .DEPTH(MAX_LEN + 1)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (j_ff),
      .wr_data (cell_cost),
      .rd_addr (j_ff),
      .rd_data (row_q)
   );

   // row zero is never stored: its cost at column j is j
   assign up_cost = (i_ff == CW'(1)) ? j_ff : row_q;

   always_comb begin
      min_cost = diag_ff;
      if (left_ff < min_cost) begin
         min_cost = left_ff;
      end
      if (up_cost < min_cost) begin
         min_cost = up_cost;
      end
      cell_cost = (a_q == b_q) ? diag_ff : CW'(min_cost + CW'(1));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      a_we         = 1'b0;
      b_we         = 1'b0;
      row_we       = 1'b0;
      finish       = 1'b0;
      fin_cost     = left_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ede_pkg::ACT_APPEND_FIRST: begin
                     if (len_a_ff < CW'(MAX_LEN)) begin
                        a_we     = 1'b1;
                        len_a_in = len_a_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ede_pkg::ACT_APPEND_SECOND: begin
                     if (len_b_ff < CW'(MAX_LEN)) begin
                        b_we     = 1'b1;
                        len_b_in = len_b_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ede_pkg::ACT_COMPUTE: begin
                     if (len_a_ff == '0) begin
                        // empty first string: distance is the second length
                        finish   = 1'b1;
                        fin_cost = len_b_ff;
                     end else begin
                        i_in     = CW'(1);
                        state_in = ST_ROW;
                     end
                  end
                  default: begin
                     // unused action, nothing happens
                  end
               endcase
            end
         end
         ST_ROW: begin
            // column zero of row i costs i, previous row's column zero is i - 1
            left_in = i_ff;
            diag_in = i_minus1;
            j_in    = CW'(1);
            if (len_b_ff == '0) begin
               if (i_ff == len_a_ff) begin
                  finish   = 1'b1;
                  fin_cost = i_ff;
               end else begin
                  i_in = i_ff + CW'(1);
               end
            end else begin
               state_in = ST_CELL_RD;
            end
         end
         ST_CELL_RD: begin
            // symbol and up cost reads in flight
            state_in = ST_CELL_CALC;
         end
         ST_CELL_CALC: begin
            row_we  = 1'b1;
            left_in = cell_cost;
            diag_in = up_cost;
            if (j_ff == len_b_ff) begin
               if (i_ff == len_a_ff) begin
                  finish   = 1'b1;
                  fin_cost = cell_cost;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = ST_ROW;
               end
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = ST_CELL_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      fin_wide = 16'(fin_cost);
      if (finish) begin
         // result beat, which also clears both strings and the overflow flag
         rsp_valid_in    = 1'b1;
         rsp_in.distance = (fin_wide > 16'(ede_pkg::DIST_MAX)) ?
                           ede_pkg::DIST_W'(ede_pkg::DIST_MAX) :
                           fin_wide[ede_pkg::DIST_W-1:0];
         rsp_in.too_long = ovf_ff;
         len_a_in        = '0;
         len_b_in        = '0;
         ovf_in          = 1'b0;
         state_in        = ST_IDLE;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
`include "edit_distance_engine_unit_assert.svh"

   // a result beat always leaves both strings cleared
   `EDE_ASSERT_SAME(a_rsp_clears, clock, reset, rsp_valid, (len_a_ff == '0) && (len_b_ff == '0) && !ovf_ff)
   // the result comes out only once the sequencer is back at rest
   `EDE_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // a cell always lies inside the kept strings
   `EDE_ASSERT_SAME(a_cell_range, clock, reset, state_ff == ST_CELL_CALC, (i_ff != '0) && (i_ff <= len_a_ff) && (j_ff != '0) && (j_ff <= len_b_ff))
   // a read cycle is always followed by its compute cycle
   `EDE_ASSERT_NEXT(a_rd_then_calc, clock, reset, state_ff == ST_CELL_RD, state_ff == ST_CELL_CALC)

endmodule
